FILE: design/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and control types for the line segment window clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  // default coordinate width
  localparam int unsigned CoordWidthDef = 16;

  // region outcode bits
  localparam logic [3:0] OcTop    = 4'h1;
  localparam logic [3:0] OcBottom = 4'h2;
  localparam logic [3:0] OcRight  = 4'h4;
  localparam logic [3:0] OcLeft   = 4'h8;

  // endpoint moves allowed per segment
  localparam int unsigned MoveLimit = 4;
  localparam int unsigned MoveWidth = $clog2(MoveLimit + 1);

  // configuration register map
  localparam int unsigned RegIdxWidth = 4;
  localparam logic [RegIdxWidth-1:0] RegWinXMin = 4'd0;
  localparam logic [RegIdxWidth-1:0] RegWinXMax = 4'd1;
  localparam logic [RegIdxWidth-1:0] RegWinYMin = 4'd2;
  localparam logic [RegIdxWidth-1:0] RegWinYMax = 4'd3;

  // window reset values
  localparam int WinXMinRst = 0;
  localparam int WinXMaxRst = 639;
  localparam int WinYMinRst = 0;
  localparam int WinYMaxRst = 479;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_step;
    logic update;
    logic finish;
  } lsc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic both_zero;
    logic share;
    logic out_free;
  } lsc_sts_t;

endpackage

`default_nettype wire

FILE: design/lsc_channels.sv
// ----------------------------------------------------------------------------
// lsc channels
// Valid/ready channel interfaces for segments, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsc_seg_if #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_res_if #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic signed [COORD_WIDTH-1:0] clip_start_x;
  logic signed [COORD_WIDTH-1:0] clip_start_y;
  logic signed [COORD_WIDTH-1:0] clip_end_x;
  logic signed [COORD_WIDTH-1:0] clip_end_y;

  modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, input ready);
  modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                  clip_end_y, output ready);
endinterface

interface lsc_cfg_if #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
);
  import lsc_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [RegIdxWidth-1:0]        reg_index;
  logic signed [COORD_WIDTH-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: design/lsc_ctrl.sv
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: outcode test, operand setup, multiply, bit-serial divide, update.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_ctrl #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsc_pkg::lsc_sts_t sts_i,
  output lsc_pkg::lsc_cmd_t cmd_o
);
  import lsc_pkg::*;

  localparam int unsigned CntWidth = $clog2(COORD_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [MoveWidth-1:0] moves_q, moves_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 done_test;

  // segment finished: accepted, rejected or out of moves
  assign done_test = sts_i.both_zero || sts_i.share ||
                     (moves_q == MoveWidth'(MoveLimit));

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        if (done_test) begin
          if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntWidth'(COORD_WIDTH - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_TEST;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // move and divide step counters
  always_comb begin
    moves_d = moves_q;
    cnt_d   = cnt_q;
    if (cmd_o.load) begin
      moves_d = '0;
    end else if (cmd_o.update) begin
      moves_d = moves_q + MoveWidth'(1);
    end
    if (cmd_o.mul) begin
      cnt_d = '0;
    end else if (cmd_o.div_step) begin
      cnt_d = cnt_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      moves_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      moves_q <= moves_d;
      cnt_q   <= cnt_d;
    end
  end

  // checks
  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("result written while output register still full");
  a_move_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> moves_q < MoveWidth'(MoveLimit))
    else $error("endpoint move beyond limit");
  a_upd_to_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |=> state_q == S_TEST)
    else $error("update not followed by outcode test");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> (state_q == S_DIV) && (cnt_q == '0))
    else $error("divide did not start from step zero");

endmodule

`default_nettype wire

FILE: design/lsc_datapath.sv
// ----------------------------------------------------------------------------
// lsc_datapath
// Window registers, endpoints, outcodes, multiplier, restoring divider and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_datapath #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsc_pkg::lsc_cmd_t             cmd_i,
  output lsc_pkg::lsc_sts_t             sts_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  lsc_cfg_if.sink                       cfg_i,
  lsc_res_if.source                     res_o
);
  import lsc_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  typedef logic signed [W-1:0] coord_t;
  typedef logic signed [W:0]   diff_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, coord_t xmin,
                                          coord_t xmax, coord_t ymin, coord_t ymax);
    logic [3:0] c;
    c = '0;
    if (y > ymax) begin
      c = c | OcTop;
    end else if (y < ymin) begin
      c = c | OcBottom;
    end
    if (x > xmax) begin
      c = c | OcRight;
    end else if (x < xmin) begin
      c = c | OcLeft;
    end
    return c;
  endfunction

  function automatic logic [W-1:0] magnitude(diff_t v);
    diff_t n;
    n = -v;
    return v[W] ? n[W-1:0] : v[W-1:0];
  endfunction

  function automatic diff_t widen(coord_t v);
    return $signed({v[W-1], v});
  endfunction

  coord_t win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;
  coord_t x0_q, y0_q, x1_q, y1_q;
  logic [3:0] c0, c1, sel;

  // window registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_x_min_q <= coord_t'(WinXMinRst);
      win_x_max_q <= coord_t'(WinXMaxRst);
      win_y_min_q <= coord_t'(WinYMinRst);
      win_y_max_q <= coord_t'(WinYMaxRst);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        RegWinXMin: win_x_min_q <= cfg_i.wdata;
        RegWinXMax: win_x_max_q <= cfg_i.wdata;
        RegWinYMin: win_y_min_q <= cfg_i.wdata;
        RegWinYMax: win_y_max_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // outcodes of the current endpoints
  assign c0 = outcode(x0_q, y0_q, win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q);
  assign c1 = outcode(x1_q, y1_q, win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q);

  logic res_valid_q;

  assign sts_o.both_zero = (c0 | c1) == 4'h0;
  assign sts_o.share     = (c0 & c1) != 4'h0;
  assign sts_o.out_free  = !res_valid_q || res_o.ready;

  // operand setup for one boundary move
  logic          move_start, axis_y;
  coord_t        bound;
  diff_t         dx, dy, num_a, num_b, den;
  logic [W-1:0]  ua, ub_raw, uc;

  always_comb begin
    move_start = c0 != 4'h0;
    sel        = move_start ? c0 : c1;
    axis_y     = (sel & (OcTop | OcBottom)) != 4'h0;
    if (axis_y) begin
      bound = ((sel & OcTop) != 4'h0) ? win_y_max_q : win_y_min_q;
    end else begin
      bound = ((sel & OcRight) != 4'h0) ? win_x_max_q : win_x_min_q;
    end
    dx     = widen(x1_q) - widen(x0_q);
    dy     = widen(y1_q) - widen(y0_q);
    num_a  = axis_y ? dx : dy;
    num_b  = axis_y ? (widen(bound) - widen(y0_q)) : (widen(bound) - widen(x0_q));
    den    = axis_y ? dy : dx;
    ua     = magnitude(num_a);
    ub_raw = magnitude(num_b);
    uc     = magnitude(den);
  end

  logic [W-1:0]   ua_q, ub_q, uc_q;
  logic           neg_q, move_start_q, axis_y_q;
  coord_t         bound_q, base_q;
  logic [2*W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      ua_q         <= ua;
      ub_q         <= (ub_raw > uc) ? uc : ub_raw;
      uc_q         <= uc;
      neg_q        <= num_a[W] ^ num_b[W] ^ den[W];
      move_start_q <= move_start;
      axis_y_q     <= axis_y;
      bound_q      <= bound;
      base_q       <= axis_y ? x0_q : y0_q;
    end
  end

  // restoring divide step, one quotient bit per cycle
  logic [W:0] shifted, rem_n;
  logic       ge;

  always_comb begin
    shifted = {acc_q[2*W-1:W], acc_q[W-1]};
    ge      = shifted >= {1'b0, uc_q};
    rem_n   = ge ? (shifted - {1'b0, uc_q}) : shifted;
  end

  // product then quotient share one accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      acc_q <= {{W{1'b0}}, ua_q} * {{W{1'b0}}, ub_q};
    end else if (cmd_i.div_step) begin
      acc_q <= {rem_n[W-1:0], acc_q[W-2:0], ge};
    end
  end

  // new endpoint coordinate
  logic [W-1:0] quo;
  diff_t        q_signed, new_sum;
  coord_t       new_x, new_y;

  always_comb begin
    quo      = (uc_q == '0) ? '0 : acc_q[W-1:0];
    q_signed = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    new_sum  = widen(base_q) + q_signed;
    new_x    = axis_y_q ? new_sum[W-1:0] : bound_q;
    new_y    = axis_y_q ? bound_q : new_sum[W-1:0];
  end

  // endpoint registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= start_x_i;
      y0_q <= start_y_i;
      x1_q <= end_x_i;
      y1_q <= end_y_i;
    end else if (cmd_i.update) begin
      if (move_start_q) begin
        x0_q <= new_x;
        y0_q <= new_y;
      end else begin
        x1_q <= new_x;
        y1_q <= new_y;
      end
    end
  end

  // result register
  logic   res_acc_q;
  coord_t res_sx_q, res_sy_q, res_ex_q, res_ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_acc_q <= sts_o.both_zero;
      res_sx_q  <= sts_o.both_zero ? x0_q : '0;
      res_sy_q  <= sts_o.both_zero ? y0_q : '0;
      res_ex_q  <= sts_o.both_zero ? x1_q : '0;
      res_ey_q  <= sts_o.both_zero ? y1_q : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.accepted     = res_acc_q;
  assign res_o.clip_start_x = res_sx_q;
  assign res_o.clip_start_y = res_sy_q;
  assign res_o.clip_end_x   = res_ex_q;
  assign res_o.clip_end_y   = res_ey_q;

  // checks
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_acc_q |-> (res_sx_q == '0) && (res_sy_q == '0) &&
                                  (res_ex_q == '0) && (res_ey_q == '0))
    else $error("rejected segment carries nonzero coordinates");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> uc_q != '0)
    else $error("zero divisor on boundary move");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> res_valid_q)
    else $error("finished segment not presented");

endmodule

`default_nettype wire

FILE: design/line_segment_window_clipper.sv
// Each segment is loaded and given the outcode test; each of m (0..4) boundary
// moves then repeats the test, until the segment is accepted, rejected or out of moves.
// Each move is a test/setup step, one multiply, COORD_WIDTH divide steps
// of the shared restoring divider, and one update step.
// Segments are taken one at a time, after the last result enters a free result register.
// Reset clears control and loads the window with 0..639 by 0..479.
// ----------------------------------------------------------------------------
// line_segment_window_clipper
// Region outcode line clipping against a programmable rectangular window.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clipper #(
  parameter int unsigned COORD_WIDTH = lsc_pkg::CoordWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsc_seg_if.sink   seg_i,
  lsc_cfg_if.sink   cfg_i,
  lsc_res_if.source res_o
);
  import lsc_pkg::*;

  lsc_cmd_t cmd;
  lsc_sts_t sts;
  logic     in_ready;

  assign seg_i.ready = in_ready;

  // sequencer
  lsc_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  lsc_datapath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .start_x_i (seg_i.start_x),
    .start_y_i (seg_i.start_y),
    .end_x_i   (seg_i.end_x),
    .end_y_i   (seg_i.end_y),
    .cfg_i     (cfg_i),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
